/* hdl/mdd_pkg.sv */
package mdd_pkg;

  localparam int NUM_DIGITS  = 6;
  localparam int COUNT_WIDTH = 8;

  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 4;
  localparam int ANODE_W = 6;
  localparam int LEVEL_W = 8;
  localparam int DIG_W   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int CMP_W   = (COUNT_WIDTH > LEVEL_W) ? COUNT_WIDTH : LEVEL_W;

  localparam logic [LEVEL_W-1:0] DEFAULT_LEVEL = LEVEL_W'(254);
  localparam logic [CODE_W-1:0]  BLANK_CODE    = CODE_W'(11);
  localparam logic [ANODE_W-1:0] ANODES_OFF    = '0;

  localparam logic [BYTE_W-1:0] CMD_DIGITS = BYTE_W'(1);
  localparam logic [BYTE_W-1:0] CMD_LEVELS = BYTE_W'(2);

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef logic [NUM_DIGITS-1:0][CODE_W-1:0]  codes_t;
  typedef logic [NUM_DIGITS-1:0][LEVEL_W-1:0] levels_t;

  // one request as it leaves the input register
  typedef struct packed {
    logic              fire;
    logic              opcode;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

endpackage

/* hdl/mdd_if.sv */
interface mdd_in_if;
  import mdd_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface mdd_out_if;
  import mdd_pkg::*;

  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  decoder_code;
  logic [ANODE_W-1:0] anode_mask;

  modport source (output valid, output decoder_code, output anode_mask, input ready);
  modport sink (input valid, input decoder_code, input anode_mask, output ready);
endinterface

/* hdl/mdd_rx.sv */
module mdd_rx (
  input  logic            clk,
  input  logic            rst_n,
  input  mdd_pkg::item_t  item,
  output mdd_pkg::codes_t codes,
  output mdd_pkg::levels_t levels
);
  import mdd_pkg::*;

  localparam logic [1:0] MODE_CMD    = 2'd0;
  localparam logic [1:0] MODE_DIGITS = 2'd1;
  localparam logic [1:0] MODE_LEVELS = 2'd2;

  logic [1:0]       mode_r, mode_nxt;
  logic [DIG_W-1:0] idx_r, idx_nxt;
  codes_t           codes_r, codes_nxt;
  levels_t          levels_r, levels_nxt;
  logic             last;

  assign last = (idx_r == DIG_W'(NUM_DIGITS - 1));

  always_comb begin
    mode_nxt   = mode_r;
    idx_nxt    = idx_r;
    codes_nxt  = codes_r;
    levels_nxt = levels_r;
    if (item.fire && item.opcode == OP_BYTE) begin
      case (mode_r)
        MODE_CMD: begin
          if (item.rx_byte == CMD_DIGITS) begin
            mode_nxt = MODE_DIGITS;
            idx_nxt  = '0;
          end else if (item.rx_byte == CMD_LEVELS) begin
            mode_nxt = MODE_LEVELS;
            idx_nxt  = '0;
          end
        end
        MODE_DIGITS, MODE_LEVELS: begin
          if (mode_r == MODE_DIGITS) begin
            codes_nxt[idx_r] = item.rx_byte[CODE_W-1:0];
          end else begin
            levels_nxt[idx_r] = item.rx_byte;
          end
          if (last) begin
            idx_nxt  = '0;
            mode_nxt = MODE_CMD;
          end else begin
            idx_nxt = idx_r + DIG_W'(1);
          end
        end
        default: begin
          // stray mode code drops the byte and resyncs
          mode_nxt = MODE_CMD;
          idx_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_CMD;
      idx_r    <= '0;
      codes_r  <= '0;
      levels_r <= {NUM_DIGITS{DEFAULT_LEVEL}};
    end else begin
      mode_r   <= mode_nxt;
      idx_r    <= idx_nxt;
      codes_r  <= codes_nxt;
      levels_r <= levels_nxt;
    end
  end

  assign codes  = codes_r;
  assign levels = levels_r;

endmodule

/* hdl/mdd_scan.sv */
module mdd_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mdd_pkg::item_t                item,
  input  mdd_pkg::codes_t               codes,
  input  mdd_pkg::levels_t              levels,
  output logic [mdd_pkg::CODE_W-1:0]    decoder_nxt,
  output logic [mdd_pkg::ANODE_W-1:0]   anode_nxt
);
  import mdd_pkg::*;

  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [DIG_W-1:0]       scan_r, scan_nxt;
  logic [CODE_W-1:0]      dec_r, dec_nxt;
  logic [ANODE_W-1:0]     anode_r, anode_nxt_i;
  logic [DIG_W-1:0]       lit;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [ANODE_W-1:0]     onehot;

  assign cnt_inc = cnt_r + COUNT_WIDTH'(1);

  // anode bits past the field width are dropped
  always_comb begin
    for (int i = 0; i < ANODE_W; i++) begin
      onehot[i] = (CMP_W'(scan_r) == CMP_W'(i));
    end
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    scan_nxt    = scan_r;
    dec_nxt     = dec_r;
    anode_nxt_i = anode_r;
    lit         = '0;
    if (item.fire && item.opcode == OP_TICK) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc == '0) begin
        dec_nxt     = codes[scan_r];
        anode_nxt_i = onehot;
        scan_nxt    = (scan_r == DIG_W'(NUM_DIGITS - 1)) ? '0 : scan_r + DIG_W'(1);
      end
      // digit on the anodes is the one before the scan pointer
      lit = (scan_nxt == '0) ? DIG_W'(NUM_DIGITS - 1) : scan_nxt - DIG_W'(1);
      if (CMP_W'(cnt_inc) == CMP_W'(levels[lit])) begin
        dec_nxt     = BLANK_CODE;
        anode_nxt_i = ANODES_OFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      scan_r  <= '0;
      dec_r   <= '0;
      anode_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      scan_r  <= scan_nxt;
      dec_r   <= dec_nxt;
      anode_r <= anode_nxt_i;
    end
  end

  assign decoder_nxt = dec_nxt;
  assign anode_nxt   = anode_nxt_i;

endmodule

/* hdl/multiplexed_digit_driver_serial_load_unit.sv */
// multiplexed six-digit display driver with serial loading and pwm brightness
//
// in_ch carries one request per item: opcode 0 is a received serial byte
// (rx_byte), opcode 1 is one prescaled timer tick. out_ch returns exactly one
// result per request: the decoder code and anode mask being driven after it.
// byte 1 in command mode loads six digit codes, byte 2 loads six brightness
// levels; other command bytes are ignored.
// path: an accepted request passes the input register, then the result
// register, from which out_ch takes it. one request per cycle is sustained
// while out_ch is ready; the state update is a single pass between the two
// registers.
// when out_ch stalls, the result register holds and the input register still
// takes one more request, so in_ch.ready drops only when both are full.
// reset (rst_n low, synchronous) empties both registers, puts the parser in
// command mode, clears digit codes, sets all brightness levels to 254 and
// clears the period counter, scan pointer and scan code and mask; out_ch data is not reset.
module multiplexed_digit_driver_serial_load_unit (
  input logic      clk,
  input logic      rst_n,
  mdd_in_if.sink   in_ch,
  mdd_out_if.source out_ch
);
  import mdd_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_op_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] out_dec_r;
  logic [ANODE_W-1:0] out_anode_r;
  logic              out_adv;
  logic              in_rdy;
  item_t             item;
  codes_t            codes;
  levels_t           levels;
  logic [CODE_W-1:0] dec_nxt;
  logic [ANODE_W-1:0] anode_nxt;

  assign out_adv = !out_valid_r || out_ch.ready;
  assign in_rdy  = !s1_valid_r || out_adv;

  assign item = '{fire: s1_valid_r && out_adv, opcode: s1_op_r, rx_byte: s1_byte_r};

  mdd_rx u_rx (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .codes  (codes),
    .levels (levels)
  );

  mdd_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (item),
    .codes       (codes),
    .levels      (levels),
    .decoder_nxt (dec_nxt),
    .anode_nxt   (anode_nxt)
  );

  assign s1_valid_nxt  = in_rdy ? in_ch.valid : s1_valid_r;
  assign out_valid_nxt = out_adv ? item.fire : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      s1_op_r   <= in_ch.opcode;
      s1_byte_r <= in_ch.rx_byte;
    end
    if (item.fire) begin
      out_dec_r   <= dec_nxt;
      out_anode_r <= anode_nxt;
    end
  end

  assign in_ch.ready         = in_rdy;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.decoder_code = out_dec_r;
  assign out_ch.anode_mask   = out_anode_r;

endmodule
